/* hdl/pmc_pkg.sv */
`default_nettype none
package pmc_pkg;

   localparam int ANG_W      = 16;
   localparam int E_W        = 16;
   localparam int R_W        = 15;
   localparam int VTX_W      = 16;
   localparam int MOM_W      = 17;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_VERTEX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_X   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_Y   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_Z   = 2'd3;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN   = 24;

   // q30 values, cordic datapath, phase accumulator
   localparam int Q_W        = 32;
   localparam int XY_W       = 34;
   localparam int Z_W        = 33;
   localparam int PROD_W     = 2 * Q_W;
   localparam int FRAC       = 30;
   localparam int R_FRAC     = 22;
   localparam int VTX_SHIFT  = 8;

   // coordinate offsets, squared lengths, lengths, divider
   localparam int D_W        = 26;
   localparam int SQ_W       = 52;
   localparam int L_W        = SQ_W / 2;
   localparam int QUO_W      = 31;
   localparam int NUM_W      = D_W + FRAC;
   localparam int RP_W       = R_W + 1 + Q_W;
   localparam int EP_W       = E_W + 1 + Q_W;

   localparam logic signed [XY_W-1:0]   CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [Z_W-1:0]    Z_QUARTER   = 33'sd1073741824;
   localparam logic signed [Z_W-1:0]    Z_HALF      = 33'sd2147483648;
   localparam logic signed [PROD_W-1:0] HALF_Q30    = 64'sd536870912;
   localparam logic signed [RP_W-1:0]   HALF_Q22    = 48'sd2097152;
   localparam logic signed [EP_W-1:0]   HALF_E      = 49'sd536870912;
   localparam logic signed [MOM_W-1:0]  MOM_MAX     = 17'sd65535;

   typedef struct packed {
      logic [E_W-1:0]        energy;
      logic signed [Q_W-1:0] ox;
      logic signed [Q_W-1:0] oy;
      logic signed [Q_W-1:0] oz;
   } tail_type;

   typedef struct packed {
      tail_type              tail;
      logic signed [D_W-1:0] dx;
      logic signed [D_W-1:0] dy;
      logic signed [D_W-1:0] dz;
   } geo_type;

   function automatic logic [31:0] atan_phase(input int idx);
      case (idx)
         0:  atan_phase = 32'h20000000;
         1:  atan_phase = 32'h12E4051E;
         2:  atan_phase = 32'h09FB385B;
         3:  atan_phase = 32'h051111D4;
         4:  atan_phase = 32'h028B0D43;
         5:  atan_phase = 32'h0145D7E1;
         6:  atan_phase = 32'h00A2F61E;
         7:  atan_phase = 32'h00517C55;
         8:  atan_phase = 32'h0028BE53;
         9:  atan_phase = 32'h00145F2F;
         10: atan_phase = 32'h000A2F98;
         11: atan_phase = 32'h000517CC;
         12: atan_phase = 32'h00028BE6;
         13: atan_phase = 32'h000145F3;
         14: atan_phase = 32'h0000A2F9;
         15: atan_phase = 32'h0000517C;
         16: atan_phase = 32'h000028BE;
         17: atan_phase = 32'h0000145F;
         18: atan_phase = 32'h00000A2F;
         19: atan_phase = 32'h00000517;
         20: atan_phase = 32'h0000028B;
         21: atan_phase = 32'h00000145;
         22: atan_phase = 32'h000000A2;
         23: atan_phase = 32'h00000051;
         default: atan_phase = '0;
      endcase
   endfunction

   function automatic logic signed [Q_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
      rnd_q30 = Q_W'((p + HALF_Q30) >>> FRAC);
   endfunction

   function automatic logic signed [MOM_W-1:0] sat_mom(input logic signed [EP_W-1:0] p);
      logic signed [EP_W-1:0] v;
      v = (p + HALF_E) >>> FRAC;
      if (v > EP_W'(MOM_MAX))
         sat_mom = MOM_MAX;
      else if (v < -EP_W'(MOM_MAX))
         sat_mom = -MOM_MAX;
      else
         sat_mom = MOM_W'(v);
   endfunction

endpackage
`default_nettype wire

/* hdl/pmc_cordic.sv */
`default_nettype none
module pmc_cordic
   import pmc_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ANG_W-1:0]      angle,
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  out_valid,
   output logic signed [Q_W-1:0] cos_out,
   output logic signed [Q_W-1:0] sin_out,
   output logic [SIDE_W-1:0]     side_out
);

   logic signed [XY_W-1:0] x_ff [0:STAGES];
   logic signed [XY_W-1:0] y_ff [0:STAGES];
   logic signed [Z_W-1:0]  z_ff [0:STAGES];
   logic [SIDE_W-1:0]      side_ff [0:STAGES];
   logic [STAGES:0]        flip_ff;
   logic [STAGES+1:0]      valid_ff;
   logic signed [Q_W-1:0]  cos_ff;
   logic signed [Q_W-1:0]  sin_ff;
   logic [SIDE_W-1:0]      side_out_ff;
   logic signed [Z_W-1:0]  z_raw;
   logic signed [Z_W-1:0]  z_in;
   logic                   flip_in;

   // fold the phase into the right half plane, negate the result later
   always_comb begin
      z_raw   = Z_W'($signed({angle, {(Q_W-ANG_W){1'b0}}}));
      z_in    = z_raw;
      flip_in = 1'b0;
      if (z_raw > Z_QUARTER) begin
         z_in    = z_raw - Z_HALF;
         flip_in = 1'b1;
      end else if (z_raw < -Z_QUARTER) begin
         z_in    = z_raw + Z_HALF;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
      side_ff[0] <= side_in;
      for (int i = 0; i < STAGES; i++) begin
         flip_ff[i+1] <= flip_ff[i];
         side_ff[i+1] <= side_ff[i];
         if (!z_ff[i][Z_W-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - $signed({1'b0, atan_phase(i)});
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + $signed({1'b0, atan_phase(i)});
         end
      end
      cos_ff      <= flip_ff[STAGES] ? Q_W'(-x_ff[STAGES]) : Q_W'(x_ff[STAGES]);
      sin_ff      <= flip_ff[STAGES] ? Q_W'(-y_ff[STAGES]) : Q_W'(y_ff[STAGES]);
      side_out_ff <= side_ff[STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES:0], in_valid};
      end
   end

   assign out_valid = valid_ff[STAGES+1];
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign side_out  = side_out_ff;

endmodule
`default_nettype wire

/* hdl/pmc_isqrt.sv */
`default_nettype none
module pmc_isqrt
   import pmc_pkg::*;
#(
   parameter int IN_BITS = SQ_W,
   parameter int SIDE_W  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [IN_BITS-1:0]   value,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output logic [IN_BITS/2-1:0] root,
   output logic [SIDE_W-1:0]    side_out
);

   localparam int ITER = IN_BITS / 2;

   logic [IN_BITS-1:0] v_ff [0:ITER];
   logic [IN_BITS-1:0] r_ff [0:ITER];
   logic [SIDE_W-1:0]  side_ff [0:ITER];
   logic [ITER:0]      valid_ff;

   // one result bit per stage, test bit walks down by two each stage
   always_ff @(posedge clock) begin
      v_ff[0]    <= value;
      r_ff[0]    <= '0;
      side_ff[0] <= side_in;
      for (int k = 0; k < ITER; k++) begin
         side_ff[k+1] <= side_ff[k];
         if (v_ff[k] >= r_ff[k] + (IN_BITS'(1) << (IN_BITS - 2 - 2 * k))) begin
            v_ff[k+1] <= v_ff[k] - (r_ff[k] + (IN_BITS'(1) << (IN_BITS - 2 - 2 * k)));
            r_ff[k+1] <= (r_ff[k] >> 1) + (IN_BITS'(1) << (IN_BITS - 2 - 2 * k));
         end else begin
            v_ff[k+1] <= v_ff[k];
            r_ff[k+1] <= r_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ITER-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ITER];
   assign root      = r_ff[ITER][IN_BITS/2-1:0];
   assign side_out  = side_ff[ITER];

endmodule
`default_nettype wire

/* hdl/pmc_div.sv */
`default_nettype none
module pmc_div
   import pmc_pkg::*;
#(
   parameter int NUM_BITS = NUM_W,
   parameter int DEN_BITS = L_W,
   parameter int QUO_BITS = QUO_W,
   parameter int SIDE_W   = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                out_valid,
   output logic [QUO_BITS-1:0] quotient,
   output logic [SIDE_W-1:0]   side_out
);

   // the quotient is known to fit, so the top numerator bits start below den
   logic [DEN_BITS-1:0] p_ff [0:QUO_BITS];
   logic [DEN_BITS-1:0] d_ff [0:QUO_BITS];
   logic [QUO_BITS-1:0] n_ff [0:QUO_BITS];
   logic [SIDE_W-1:0]   side_ff [0:QUO_BITS];
   logic [QUO_BITS:0]   valid_ff;
   logic [DEN_BITS:0]   trial [0:QUO_BITS-1];
   logic                ge [0:QUO_BITS-1];

   always_comb begin
      for (int k = 0; k < QUO_BITS; k++) begin
         trial[k] = {p_ff[k], n_ff[k][QUO_BITS-1]};
         ge[k]    = trial[k] >= {1'b0, d_ff[k]};
      end
   end

   // numerator bits shift out at the top, quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      p_ff[0]    <= DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
      n_ff[0]    <= num[QUO_BITS-1:0];
      d_ff[0]    <= den;
      side_ff[0] <= side_in;
      for (int k = 0; k < QUO_BITS; k++) begin
         d_ff[k+1]    <= d_ff[k];
         side_ff[k+1] <= side_ff[k];
         n_ff[k+1]    <= {n_ff[k][QUO_BITS-2:0], ge[k]};
         p_ff[k+1]    <= ge[k] ? DEN_BITS'(trial[k] - {1'b0, d_ff[k]})
                               : trial[k][DEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QUO_BITS-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[QUO_BITS];
   assign quotient  = n_ff[QUO_BITS];
   assign side_out  = side_ff[QUO_BITS];

endmodule
`default_nettype wire

/* hdl/photon_momentum_from_cluster_unit.sv */
`default_nettype none
// Photon momentum from a calorimeter cluster: energy, polar angle, azimuth
// and radius in, momentum vector and energy out.
// A request is taken on every clock edge where start is high; busy is never
// raised, so one cluster can enter each cycle.
// Each request gives exactly one result, shown for one cycle with rsp_valid.
// The path runs through the cordic pipeline, the 26-step root pipeline, the
// 31-step divider pipeline and the multiply and glue stages a-e and g-k.
// Throughput is one result per cycle in steady state.
// The receiver must take each result in the cycle it appears; there is no
// backpressure and nothing is held.
// Registers are written through csr_we/csr_index/csr_wdata and should only
// change while no request is in flight. Reset clears the pipeline valid bits
// and the registers (origin mode, vertex at zero).
module photon_momentum_from_cluster_unit
   import pmc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [E_W-1:0]          req_energy,
   input  logic [ANG_W-1:0]        req_polar_angle,
   input  logic signed [ANG_W-1:0] req_azimuth,
   input  logic [R_W-1:0]          req_radius,
   output logic                    rsp_valid,
   output logic signed [MOM_W-1:0] rsp_mom_x,
   output logic signed [MOM_W-1:0] rsp_mom_y,
   output logic signed [MOM_W-1:0] rsp_mom_z,
   output logic [E_W-1:0]          rsp_energy_out,
   output logic                    rsp_direction_valid,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LATENCY = (CORDIC_STAGES + 2) + 5 + (SQ_W / 2 + 1) + (QUO_W + 1) + 5;
   localparam int TAIL_W  = $bits(tail_type);

   logic                    use_vertex_ff;
   logic signed [VTX_W-1:0] vertex_x_ff, vertex_y_ff, vertex_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_vertex_ff <= 1'b0;
         vertex_x_ff   <= '0;
         vertex_y_ff   <= '0;
         vertex_z_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_USE_VERTEX: use_vertex_ff <= csr_wdata[0];
            CSR_VERTEX_X:   vertex_x_ff   <= $signed(csr_wdata);
            CSR_VERTEX_Y:   vertex_y_ff   <= $signed(csr_wdata);
            CSR_VERTEX_Z:   vertex_z_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // angle units
   logic                  th_valid, ph_valid;
   logic signed [Q_W-1:0] ct, st, cp, sp;
   logic [E_W-1:0]        e_c;
   logic [R_W-1:0]        r_c;

   pmc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(E_W)) u_cordic_theta (
      .clock(clock), .reset(reset), .in_valid(start && !busy),
      .angle(req_polar_angle), .side_in(req_energy),
      .out_valid(th_valid), .cos_out(ct), .sin_out(st), .side_out(e_c)
   );

   pmc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(R_W)) u_cordic_phi (
      .clock(clock), .reset(reset), .in_valid(start && !busy),
      .angle($unsigned(req_azimuth)), .side_in(req_radius),
      .out_valid(ph_valid), .cos_out(cp), .sin_out(sp), .side_out(r_c)
   );

   // a: sin theta products, b: origin direction, c: scale by radius,
   // d: offset from vertex, e: squares
   logic                     a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic signed [PROD_W-1:0] pcx_a_ff, pcy_a_ff;
   logic signed [Q_W-1:0]    ct_a_ff;
   logic [E_W-1:0]           e_a_ff, e_b_ff, e_c_ff, e_d_ff, e_e_ff;
   logic [R_W-1:0]           r_a_ff, r_b_ff;
   logic signed [Q_W-1:0]    ox_b_ff, oy_b_ff, oz_b_ff;
   logic signed [Q_W-1:0]    ox_c_ff, oy_c_ff, oz_c_ff;
   logic signed [Q_W-1:0]    ox_d_ff, oy_d_ff, oz_d_ff;
   logic signed [Q_W-1:0]    ox_e_ff, oy_e_ff, oz_e_ff;
   logic signed [RP_W-1:0]   rx_c_ff, ry_c_ff, rz_c_ff;
   logic signed [D_W-1:0]    dx_d_ff, dy_d_ff, dz_d_ff;
   logic signed [D_W-1:0]    dx_e_ff, dy_e_ff, dz_e_ff;
   logic [SQ_W-1:0]          sqx_e_ff, sqy_e_ff, sqz_e_ff;

   always_ff @(posedge clock) begin
      pcx_a_ff <= st * cp;
      pcy_a_ff <= st * sp;
      ct_a_ff  <= ct;
      e_a_ff   <= e_c;
      r_a_ff   <= r_c;

      ox_b_ff  <= rnd_q30(pcx_a_ff);
      oy_b_ff  <= rnd_q30(pcy_a_ff);
      oz_b_ff  <= ct_a_ff;
      e_b_ff   <= e_a_ff;
      r_b_ff   <= r_a_ff;

      rx_c_ff  <= RP_W'($signed({1'b0, r_b_ff})) * RP_W'(ox_b_ff);
      ry_c_ff  <= RP_W'($signed({1'b0, r_b_ff})) * RP_W'(oy_b_ff);
      rz_c_ff  <= RP_W'($signed({1'b0, r_b_ff})) * RP_W'(oz_b_ff);
      ox_c_ff  <= ox_b_ff;
      oy_c_ff  <= oy_b_ff;
      oz_c_ff  <= oz_b_ff;
      e_c_ff   <= e_b_ff;

      dx_d_ff  <= D_W'((rx_c_ff + HALF_Q22) >>> R_FRAC) - (D_W'(vertex_x_ff) <<< VTX_SHIFT);
      dy_d_ff  <= D_W'((ry_c_ff + HALF_Q22) >>> R_FRAC) - (D_W'(vertex_y_ff) <<< VTX_SHIFT);
      dz_d_ff  <= D_W'((rz_c_ff + HALF_Q22) >>> R_FRAC) - (D_W'(vertex_z_ff) <<< VTX_SHIFT);
      ox_d_ff  <= ox_c_ff;
      oy_d_ff  <= oy_c_ff;
      oz_d_ff  <= oz_c_ff;
      e_d_ff   <= e_c_ff;

      sqx_e_ff <= SQ_W'(SQ_W'(dx_d_ff) * SQ_W'(dx_d_ff));
      sqy_e_ff <= SQ_W'(SQ_W'(dy_d_ff) * SQ_W'(dy_d_ff));
      sqz_e_ff <= SQ_W'(SQ_W'(dz_d_ff) * SQ_W'(dz_d_ff));
      dx_e_ff  <= dx_d_ff;
      dy_e_ff  <= dy_d_ff;
      dz_e_ff  <= dz_d_ff;
      ox_e_ff  <= ox_d_ff;
      oy_e_ff  <= oy_d_ff;
      oz_e_ff  <= oz_d_ff;
      e_e_ff   <= e_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= th_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // lengths
   logic [SQ_W-1:0] lxy2_in, l2_in;
   logic            ok_in;
   geo_type         geo_in, geo_s;
   logic            sq_valid, sq2_valid, ok_s;
   logic [L_W-1:0]  lxy_s, l_s;

   always_comb begin
      lxy2_in            = sqx_e_ff + sqy_e_ff;
      l2_in              = lxy2_in + sqz_e_ff;
      ok_in              = lxy2_in != '0;
      geo_in.tail.energy = e_e_ff;
      geo_in.tail.ox     = ox_e_ff;
      geo_in.tail.oy     = oy_e_ff;
      geo_in.tail.oz     = oz_e_ff;
      geo_in.dx          = dx_e_ff;
      geo_in.dy          = dy_e_ff;
      geo_in.dz          = dz_e_ff;
   end

   pmc_isqrt #(.IN_BITS(SQ_W), .SIDE_W($bits(geo_type))) u_isqrt_lxy (
      .clock(clock), .reset(reset), .in_valid(e_valid_ff), .value(lxy2_in),
      .side_in(geo_in), .out_valid(sq_valid), .root(lxy_s), .side_out(geo_s)
   );

   pmc_isqrt #(.IN_BITS(SQ_W), .SIDE_W(1)) u_isqrt_l (
      .clock(clock), .reset(reset), .in_valid(e_valid_ff), .value(l2_in),
      .side_in(ok_in), .out_valid(sq2_valid), .root(l_s), .side_out(ok_s)
   );

   // direction cosines: magnitudes divided, signs restored afterwards
   logic [D_W-1:0]      adx, ady, adz;
   logic                dv_cos, dv_sin, dv_x, dv_y;
   logic [QUO_W-1:0]    q_cos, q_sin, q_x, q_y;
   logic [TAIL_W:0]     cos_side;
   logic                ok_q, nx_q, ny_q;

   always_comb begin
      adx = geo_s.dx[D_W-1] ? D_W'(-geo_s.dx) : D_W'(geo_s.dx);
      ady = geo_s.dy[D_W-1] ? D_W'(-geo_s.dy) : D_W'(geo_s.dy);
      adz = geo_s.dz[D_W-1] ? D_W'(-geo_s.dz) : D_W'(geo_s.dz);
   end

   pmc_div #(.NUM_BITS(NUM_W), .DEN_BITS(L_W), .QUO_BITS(QUO_W), .SIDE_W(TAIL_W + 1)) u_div_cos (
      .clock(clock), .reset(reset), .in_valid(sq_valid),
      .num({adz, {FRAC{1'b0}}}), .den(l_s), .side_in({geo_s.dz[D_W-1], geo_s.tail}),
      .out_valid(dv_cos), .quotient(q_cos), .side_out(cos_side)
   );

   pmc_div #(.NUM_BITS(NUM_W), .DEN_BITS(L_W), .QUO_BITS(QUO_W), .SIDE_W(1)) u_div_sin (
      .clock(clock), .reset(reset), .in_valid(sq_valid),
      .num({D_W'(lxy_s), {FRAC{1'b0}}}), .den(l_s), .side_in(ok_s),
      .out_valid(dv_sin), .quotient(q_sin), .side_out(ok_q)
   );

   pmc_div #(.NUM_BITS(NUM_W), .DEN_BITS(L_W), .QUO_BITS(QUO_W), .SIDE_W(1)) u_div_x (
      .clock(clock), .reset(reset), .in_valid(sq_valid),
      .num({adx, {FRAC{1'b0}}}), .den(lxy_s), .side_in(geo_s.dx[D_W-1]),
      .out_valid(dv_x), .quotient(q_x), .side_out(nx_q)
   );

   pmc_div #(.NUM_BITS(NUM_W), .DEN_BITS(L_W), .QUO_BITS(QUO_W), .SIDE_W(1)) u_div_y (
      .clock(clock), .reset(reset), .in_valid(sq_valid),
      .num({ady, {FRAC{1'b0}}}), .den(lxy_s), .side_in(geo_s.dy[D_W-1]),
      .out_valid(dv_y), .quotient(q_y), .side_out(ny_q)
   );

   // g: signed cosines, h: sin theta times azimuth cosines, i: mode select,
   // j: energy products, k: round and saturate
   tail_type                 tail_q;
   tail_type                 tail_g_ff, tail_h_ff;
   logic                     g_valid_ff, h_valid_ff, i_valid_ff, j_valid_ff, k_valid_ff;
   logic                     ok_g_ff, ok_h_ff, dir_i_ff, dir_j_ff;
   logic signed [Q_W-1:0]    cos_g_ff, sin_g_ff, qx_g_ff, qy_g_ff, cos_h_ff;
   logic signed [PROD_W-1:0] mx_h_ff, my_h_ff;
   logic signed [Q_W-1:0]    ux_i_ff, uy_i_ff, uz_i_ff;
   logic [E_W-1:0]           e_i_ff, e_j_ff, e_k_ff;
   logic signed [EP_W-1:0]   px_j_ff, py_j_ff, pz_j_ff;
   logic signed [MOM_W-1:0]  mx_k_ff, my_k_ff, mz_k_ff;
   logic                     dir_k_ff;
   logic signed [Q_W-1:0]    qc, qs, qx, qy;

   always_comb begin
      tail_q = cos_side[TAIL_W-1:0];
      qc     = $signed(Q_W'(q_cos));
      qs     = $signed(Q_W'(q_sin));
      qx     = $signed(Q_W'(q_x));
      qy     = $signed(Q_W'(q_y));
   end

   always_ff @(posedge clock) begin
      cos_g_ff  <= cos_side[TAIL_W] ? -qc : qc;
      sin_g_ff  <= qs;
      qx_g_ff   <= nx_q ? -qx : qx;
      qy_g_ff   <= ny_q ? -qy : qy;
      ok_g_ff   <= ok_q;
      tail_g_ff <= tail_q;

      mx_h_ff   <= sin_g_ff * qx_g_ff;
      my_h_ff   <= sin_g_ff * qy_g_ff;
      cos_h_ff  <= cos_g_ff;
      ok_h_ff   <= ok_g_ff;
      tail_h_ff <= tail_g_ff;

      ux_i_ff   <= use_vertex_ff ? rnd_q30(mx_h_ff) : tail_h_ff.ox;
      uy_i_ff   <= use_vertex_ff ? rnd_q30(my_h_ff) : tail_h_ff.oy;
      uz_i_ff   <= use_vertex_ff ? cos_h_ff : tail_h_ff.oz;
      dir_i_ff  <= use_vertex_ff ? ok_h_ff : 1'b1;
      e_i_ff    <= tail_h_ff.energy;

      px_j_ff   <= EP_W'($signed({1'b0, e_i_ff})) * EP_W'(ux_i_ff);
      py_j_ff   <= EP_W'($signed({1'b0, e_i_ff})) * EP_W'(uy_i_ff);
      pz_j_ff   <= EP_W'($signed({1'b0, e_i_ff})) * EP_W'(uz_i_ff);
      dir_j_ff  <= dir_i_ff;
      e_j_ff    <= e_i_ff;

      // undefined vertex direction gives a zero vector
      mx_k_ff   <= dir_j_ff ? sat_mom(px_j_ff) : '0;
      my_k_ff   <= dir_j_ff ? sat_mom(py_j_ff) : '0;
      mz_k_ff   <= dir_j_ff ? sat_mom(pz_j_ff) : '0;
      dir_k_ff  <= dir_j_ff;
      e_k_ff    <= e_j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= dv_cos;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
      end
   end

   assign rsp_valid           = k_valid_ff;
   assign rsp_mom_x           = mx_k_ff;
   assign rsp_mom_y           = my_k_ff;
   assign rsp_mom_z           = mz_k_ff;
   assign rsp_energy_out      = e_k_ff;
   assign rsp_direction_valid = dir_k_ff;

   a_cordic_aligned: assert property (@(posedge clock) disable iff (reset)
      th_valid == ph_valid)
      else $error("cordic pipelines out of step");

   a_root_aligned: assert property (@(posedge clock) disable iff (reset)
      sq_valid == sq2_valid)
      else $error("root pipelines out of step");

   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      (dv_cos == dv_sin) && (dv_cos == dv_x) && (dv_cos == dv_y))
      else $error("divider pipelines out of step");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a request at the pipeline latency");

   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_direction_valid) |->
         (rsp_mom_x == '0 && rsp_mom_y == '0 && rsp_mom_z == '0))
      else $error("nonzero momentum with undefined direction");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mom_x != -MOM_MAX - 17'sd1 && rsp_mom_y != -MOM_MAX - 17'sd1
                     && rsp_mom_z != -MOM_MAX - 17'sd1))
      else $error("momentum outside saturation range");

endmodule
`default_nettype wire
